### sv/fnp_pkg.sv
// Package: types, character codes and the IUPAC nibble table of the nibble packer.
package fnp_pkg;

  // Width of the running base count of an open record.
  localparam int CountBits = 32;
  // Result queue depth; a power of two so the pointers wrap on their own.
  localparam int FifoDepth = 4;
  localparam int FifoPtrBits = $clog2(FifoDepth);
  localparam int FifoCntBits = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowZ    = 8'h7A;
  localparam logic [7:0] CaseShift = 8'h20;

  localparam logic [3:0] NibUnknown = 4'hF;

  typedef enum logic {
    KindData,
    KindEnd
  } kind_e;

  typedef struct packed {
    logic                 at_line_start;
    logic                 in_header_line;
    logic                 record_open;
    logic                 half_valid;
    logic [3:0]           half_nibble;
    logic [CountBits-1:0] tally;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pbyte;
    logic [31:0] bases;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t r0;
    result_t r1;
  } emit_t;

  localparam state_t StateReset = '{
    at_line_start:  1'b1,
    in_header_line: 1'b0,
    record_open:    1'b0,
    half_valid:     1'b0,
    half_nibble:    4'h0,
    tally:          '0
  };

  localparam result_t ResIdle = '{
    kind:  KindData,
    pbyte: 8'h00,
    bases: 32'h0,
    last:  1'b0
  };

  // Case-folded IUPAC code of one text byte; anything unknown is N.
  function automatic logic [3:0] nibble_of(input logic [7:0] ch);
    logic [7:0] up;
    logic [3:0] nib;
    up = ch;
    if (ch >= ChLowA && ch <= ChLowZ) begin
      up = ch - CaseShift;
    end
    case (up)
      8'h2D:   nib = 4'h0; // -
      8'h41:   nib = 4'h1; // A
      8'h43:   nib = 4'h2; // C
      8'h47:   nib = 4'h3; // G
      8'h54:   nib = 4'h4; // T
      8'h52:   nib = 4'h5; // R
      8'h59:   nib = 4'h6; // Y
      8'h4D:   nib = 4'h7; // M
      8'h4B:   nib = 4'h8; // K
      8'h53:   nib = 4'h9; // S
      8'h57:   nib = 4'hA; // W
      8'h48:   nib = 4'hB; // H
      8'h42:   nib = 4'hC; // B
      8'h56:   nib = 4'hD; // V
      8'h44:   nib = 4'hE; // D
      default: nib = NibUnknown;
    endcase
    return nib;
  endfunction

  // Record count clamped to the 32-bit result field.
  function automatic logic [31:0] sat32(input logic [CountBits-1:0] t);
    logic [63:0] wide;
    wide = 64'(t);
    return (wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

endpackage

### sv/fnp_decode.sv
// Per-byte parser step: next parser state and up to two result words.
module fnp_decode (
  input  fnp_pkg::state_t st_i,
  input  logic [7:0]      text_byte_i,
  input  logic            eoi_i,
  output fnp_pkg::state_t st_o,
  output fnp_pkg::emit_t  emit_o
);

  logic           ch_nl;
  logic           ch_ws;
  logic [3:0]     nib;
  fnp_pkg::result_t flush_res;
  fnp_pkg::result_t end_res;

  assign ch_nl = (text_byte_i == fnp_pkg::ChNewline);
  assign ch_ws = (text_byte_i == fnp_pkg::ChCr) || (text_byte_i == fnp_pkg::ChSpace) ||
                 (text_byte_i == fnp_pkg::ChTab);
  assign nib   = fnp_pkg::nibble_of(text_byte_i);

  always_comb begin
    flush_res       = fnp_pkg::ResIdle;
    flush_res.pbyte = {st_i.half_nibble, 4'h0};
    end_res         = fnp_pkg::ResIdle;
    end_res.kind    = fnp_pkg::KindEnd;
    end_res.bases   = fnp_pkg::sat32(st_i.tally);
  end

  always_comb begin
    logic close;
    close         = 1'b0;
    st_o          = st_i;
    emit_o.valid0 = 1'b0;
    emit_o.valid1 = 1'b0;
    emit_o.r0     = fnp_pkg::ResIdle;
    emit_o.r1     = fnp_pkg::ResIdle;

    if (eoi_i) begin
      close = st_i.record_open;
      st_o  = fnp_pkg::StateReset;
    end else if (st_i.in_header_line) begin
      if (ch_nl) begin
        st_o.in_header_line = 1'b0;
        st_o.at_line_start  = 1'b1;
      end
    end else if (st_i.at_line_start && text_byte_i == fnp_pkg::ChGt) begin
      close               = st_i.record_open;
      st_o.record_open    = 1'b1;
      st_o.in_header_line = 1'b1;
      st_o.at_line_start  = 1'b0;
      st_o.half_valid     = 1'b0;
      st_o.half_nibble    = 4'h0;
      st_o.tally          = '0;
    end else if (ch_nl) begin
      st_o.at_line_start = 1'b1;
    end else begin
      st_o.at_line_start = 1'b0;
      if (st_i.record_open && !ch_ws) begin
        if (st_i.tally != '1) begin
          st_o.tally = st_i.tally + 1'b1;
        end
        if (!st_i.half_valid) begin
          st_o.half_nibble = nib;
          st_o.half_valid  = 1'b1;
        end else begin
          emit_o.valid0   = 1'b1;
          emit_o.r0.pbyte = {st_i.half_nibble, nib};
          st_o.half_valid  = 1'b0;
          st_o.half_nibble = 4'h0;
        end
      end
    end

    // Closing a record flushes a pending half byte ahead of the end marker.
    if (close) begin
      if (st_i.half_valid) begin
        emit_o.valid0 = 1'b1;
        emit_o.r0     = flush_res;
        emit_o.valid1 = 1'b1;
        emit_o.r1     = end_res;
      end else begin
        emit_o.valid0 = 1'b1;
        emit_o.r0     = end_res;
      end
    end

    if (emit_o.valid1) begin
      emit_o.r1.last = 1'b1;
    end else if (emit_o.valid0) begin
      emit_o.r0.last = 1'b1;
    end
  end

endmodule

### sv/fnp_out_fifo.sv
// Small result queue that takes up to two words per cycle and hands out one.
module fnp_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fnp_pkg::emit_t                  emit_i,
  input  logic                            pop_i,
  output fnp_pkg::result_t                head_o,
  output logic                            not_empty_o,
  output logic [fnp_pkg::FifoCntBits-1:0] count_o
);

  fnp_pkg::result_t                 mem_q [fnp_pkg::FifoDepth];
  logic [fnp_pkg::FifoPtrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [fnp_pkg::FifoPtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [fnp_pkg::FifoCntBits-1:0]  count_q, count_d;
  logic [fnp_pkg::FifoPtrBits-1:0]  wr_ptr_nxt;
  logic [1:0]                       n_push;

  assign wr_ptr_nxt  = wr_ptr_q + 1'b1;
  assign n_push      = 2'(emit_i.valid0) + 2'(emit_i.valid1);
  assign wr_ptr_d    = wr_ptr_q + fnp_pkg::FifoPtrBits'(n_push);
  assign rd_ptr_d    = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
  assign count_d     = count_q + fnp_pkg::FifoCntBits'(n_push)
                       - fnp_pkg::FifoCntBits'(pop_i);
  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign count_o     = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid0) begin
      mem_q[wr_ptr_q] <= emit_i.r0;
    end
    if (emit_i.valid1) begin
      mem_q[wr_ptr_nxt] <= emit_i.r1;
    end
  end

endmodule

### sv/fasta_iupac_nibble_packer_core.sv
// Top level of the FASTA to IUPAC nibble packer: input register, parser state, result queue.
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   tdata = text_byte, tlast = end_of_input
//   m_axis   out  m_axis_tvalid/m_axis_tready   tdata = packed_byte, record_bases;
//                                               tuser = item_kind, tlast = last_of_run
//
// One text byte is taken per cycle while s_axis_tready is high. A byte waits in the input
// register, where the parser step runs and writes its zero to two result words into a
// four-word queue, which offers them on m_axis in order. The input register advances only
// while at most two words are queued; with a stalled master the queue stops at three or four
// words, one more byte waits in the input register and s_axis_tready drops.
// Reset clears the parser state and empties the queue.
module fasta_iupac_nibble_packer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
  input  logic        s_axis_tlast,  // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [7:0] packed_byte, [39:8] record_bases
  output logic        m_axis_tuser,  // item_kind
  output logic        m_axis_tlast   // last_of_run
);

  logic                            in_valid_q, in_valid_d;
  logic [7:0]                      in_byte_q;
  logic                            in_eoi_q;
  fnp_pkg::state_t                 st_q, st_d;
  fnp_pkg::emit_t                  step_emit;
  fnp_pkg::emit_t                  push;
  fnp_pkg::result_t                head;
  logic [fnp_pkg::FifoCntBits-1:0] fifo_count;
  logic                            proc;
  logic                            s_accept;
  logic                            m_pop;

  // A word is parsed only when the queue is sure to hold both of its possible results.
  assign proc          = in_valid_q &&
                         (fifo_count <= fnp_pkg::FifoCntBits'(fnp_pkg::FifoDepth - 2));
  assign s_axis_tready = !in_valid_q || proc;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_accept || (in_valid_q && !proc);
  assign m_pop         = m_axis_tvalid && m_axis_tready;

  fnp_decode u_decode (
    .st_i        (st_q),
    .text_byte_i (in_byte_q),
    .eoi_i       (in_eoi_q),
    .st_o        (st_d),
    .emit_o      (step_emit)
  );

  always_comb begin
    push        = step_emit;
    push.valid0 = step_emit.valid0 && proc;
    push.valid1 = step_emit.valid1 && proc;
  end

  fnp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (push),
    .pop_i       (m_pop),
    .head_o      (head),
    .not_empty_o (m_axis_tvalid),
    .count_o     (fifo_count)
  );

  assign m_axis_tdata = {head.bases, head.pbyte};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= fnp_pkg::StateReset;
    end else begin
      in_valid_q <= in_valid_d;
      if (proc) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tlast;
    end
  end

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= fnp_pkg::FifoCntBits'(fnp_pkg::FifoDepth))
    else $error("result queue holds more words than its depth");

  a_end_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == fnp_pkg::KindEnd |->
      m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
    else $error("record end word without last flag or with nonzero data");

  a_data_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == fnp_pkg::KindData |-> m_axis_tdata[39:8] == 32'h0)
    else $error("data word carries a base count");

  a_eoi_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_eoi_q |=> !st_q.record_open && st_q.at_line_start && !st_q.half_valid)
    else $error("parser state not back to start after end of input");

endmodule

### tb/tb.sv
// Testbench of the nibble packer: directed and random FASTA streams checked against a predictor.
module tb;

  localparam int    CycleLimit  = 400_000;
  localparam int    RandomItems = 1200;
  localparam int    HoldCycles  = 200;
  // Stimulus letters; the position of a letter is its IUPAC code, N last.
  localparam string BaseLetters = "-ACGTRYMKSWHBVDN";

  typedef struct {
    fnp_pkg::kind_e kind;
    logic [7:0]     pbyte;
    logic [31:0]    bases;
    logic           last;
  } packed_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] text_byte
  logic        s_axis_tlast;   // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [7:0] packed_byte, [39:8] record_bases
  logic        m_axis_tuser;   // item_kind
  logic        m_axis_tlast;   // last_of_run

  // Parser state as the predictor sees it.
  bit                            line_start = 1'b1;
  bit                            in_header  = 1'b0;
  bit                            rec_open   = 1'b0;
  bit                            have_half  = 1'b0;
  logic [3:0]                    held_code  = 4'h0;
  logic [fnp_pkg::CountBits-1:0] open_tally = '0;

  packed_word_t words_due[$];
  int           mismatches = 0;
  int           sent_items = 0;
  int           cycles     = 0;
  int           hold_req   = 0;
  bit           quiet      = 1'b0;

  fasta_iupac_nibble_packer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [3:0] iupac_code(input logic [7:0] text);
    logic [7:0] up;
    up = (text >= "a" && text <= "z") ? text - 8'h20 : text;
    for (int i = 0; i < 15; i++) begin
      if (BaseLetters[i] == up) return i[3:0];
    end
    return fnp_pkg::NibUnknown;
  endfunction

  function automatic void push_word(input fnp_pkg::kind_e kind, input logic [7:0] pbyte,
                                    input logic [31:0] bases);
    packed_word_t w;
    w.kind  = kind;
    w.pbyte = pbyte;
    w.bases = bases;
    w.last  = 1'b0;
    words_due.insert(words_due.size(), w);
  endfunction

  function automatic void close_record();
    logic [63:0] wide;
    logic [31:0] shown;
    wide  = 64'(open_tally);
    shown = (wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    if (have_half) push_word(fnp_pkg::KindData, {held_code, 4'h0}, 32'h0);
    push_word(fnp_pkg::KindEnd, 8'h00, shown);
    have_half  = 1'b0;
    held_code  = 4'h0;
    open_tally = '0;
    rec_open   = 1'b0;
  endfunction

  // Advances the predicted parser by one accepted word and queues what it emits.
  function automatic void parse_text_byte(input logic [7:0] text, input logic eoi);
    int           queued_prior;
    packed_word_t tail;
    queued_prior = words_due.size();
    if (eoi) begin
      if (rec_open) close_record();
      line_start = 1'b1;
      in_header  = 1'b0;
    end else if (in_header) begin
      if (text == fnp_pkg::ChNewline) begin
        in_header  = 1'b0;
        line_start = 1'b1;
      end
    end else if (line_start && text == fnp_pkg::ChGt) begin
      if (rec_open) close_record();
      rec_open   = 1'b1;
      in_header  = 1'b1;
      line_start = 1'b0;
      have_half  = 1'b0;
      held_code  = 4'h0;
      open_tally = '0;
    end else if (text == fnp_pkg::ChNewline) begin
      line_start = 1'b1;
    end else begin
      line_start = 1'b0;
      if (rec_open && text != fnp_pkg::ChCr && text != fnp_pkg::ChSpace &&
          text != fnp_pkg::ChTab) begin
        if (open_tally != '1) open_tally++;
        if (!have_half) begin
          held_code = iupac_code(text);
          have_half = 1'b1;
        end else begin
          push_word(fnp_pkg::KindData, {held_code, iupac_code(text)}, 32'h0);
          have_half = 1'b0;
          held_code = 4'h0;
        end
      end
    end
    if (words_due.size() > queued_prior) begin
      tail = words_due[words_due.size() - 1];
      tail.last = 1'b1;
      words_due[words_due.size() - 1] = tail;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d, %s: got %h, expected %h", cycles, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    packed_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (words_due.size() == 0) begin
        report_mismatch("word with nothing pending", m_axis_tdata[31:0], 32'h0);
      end else begin
        want = words_due.pop_front();
        if (m_axis_tuser !== want.kind) report_mismatch("item_kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[7:0] !== want.pbyte)
          report_mismatch("packed_byte", m_axis_tdata[7:0], want.pbyte);
        if (m_axis_tdata[39:8] !== want.bases)
          report_mismatch("record_bases", m_axis_tdata[39:8], want.bases);
        if (m_axis_tlast !== want.last) report_mismatch("last_of_run", m_axis_tlast, want.last);
      end
    end
  end

  // Receiver: short random stalls, now and then a long one, and a requested hold-off.
  initial begin
    int pause;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        pause    = hold_req;
        hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (quiet) begin
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(8, 30)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL fasta_iupac_nibble_packer_core");
    $finish;
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  task automatic send_item(input logic [7:0] text, input logic eoi);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= text;
    s_axis_tlast  <= eoi;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    parse_text_byte(text, eoi);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Always waits for a clock edge so valid is never lowered and raised in one step.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (words_due.size() != 0);
  endtask

  function automatic logic [7:0] sequence_char();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 82) begin
      c = BaseLetters[$urandom_range(0, 15)];
      if (c != "-" && $urandom_range(0, 1)) c = c | 8'h20;
    end else if (r < 90) begin
      case ($urandom_range(0, 2))
        0:       c = fnp_pkg::ChSpace;
        1:       c = fnp_pkg::ChTab;
        default: c = fnp_pkg::ChCr;
      endcase
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic send_record();
    logic [7:0] c;
    send_item(fnp_pkg::ChGt, 1'b0);
    repeat ($urandom_range(0, 4)) begin
      c = 8'($urandom_range(0, 255));
      send_item(c == fnp_pkg::ChNewline ? fnp_pkg::ChSpace : c, 1'b0);
    end
    send_item(fnp_pkg::ChNewline, 1'b0);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 12)) send_item(sequence_char(), 1'b0);
      send_item(fnp_pkg::ChNewline, 1'b0);
    end
  endtask

  // Noise before any header, whitespace, '>' inside a line, byte extremes,
  // an empty record, and an odd count flushed by the end of input.
  task automatic test_directed();
    send_item(8'h00, 1'b1);
    send_text("q\n>h\nAC \t");
    send_item(fnp_pkg::ChCr, 1'b0);
    send_text("g>");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("\n>\n>\nt");
    send_item(8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (6) send_record();
    send_item(8'h00, 1'b1);
    wait_drained();
    quiet = 1'b0;
  endtask

  // The receiver holds off while bases keep coming, so the block must stall its input.
  task automatic test_hold_off();
    quiet    = 1'b1;
    hold_req = HoldCycles;
    send_text(">\n");
    repeat (80) send_item(BaseLetters[$urandom_range(1, 4)], 1'b0);
    send_item(8'h00, 1'b1);
    wait_drained();
    quiet = 1'b0;
  endtask

  task automatic test_random_stream();
    int start;
    int r;
    start = sent_items;
    while (sent_items - start < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_item(8'($urandom_range(0, 255)), 1'b0);
      else if (r < 14) send_item(8'($urandom_range(0, 255)), 1'b1);
      else send_record();
    end
    send_item(8'h00, 1'b1);
    wait_drained();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_back_to_back();
    test_hold_off();
    test_random_stream();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS fasta_iupac_nibble_packer_core");
    end else begin
      $display("FAIL fasta_iupac_nibble_packer_core");
    end
    $finish;
  end

endmodule

### sim.f
sv/fnp_pkg.sv
sv/fnp_decode.sv
sv/fnp_out_fifo.sv
sv/fasta_iupac_nibble_packer_core.sv
tb/tb.sv
